### sv/wsm_pkg.sv
`timescale 1ns / 1ps
package wsm_pkg;
    localparam int ServicePeriod = 15;
    localparam int DcCoef        = 13422;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE  = 2'd1;
    localparam logic [1:0] CFG_DIVIDER = 2'd2;
    localparam logic [1:0] CFG_GAIN    = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [7:0] CHAN_BASE = 8'h40;
endpackage

### sv/wavetable_sound_channel_mixer_unit.sv
`timescale 1ns / 1ps
// channel  | direction | signals
// s_       | in        | s_valid s_ready s_command s_ram_addr s_ram_data
// m_       | out       | m_valid m_ready m_sample
// cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data
// A write transaction is taken in the idle state. A tick services a channel when
// one is due (eight channel byte reads, a 7-step phase reduction, three phase
// write-backs and a wave byte read), and on a sample tick computes a sum of the
// channel levels, a serial 22-step divide by the channel count and a 3-step
// multiplication of the DC blocker coefficient in 16-bit slices.
// After reset a clearing pass zeroes the sound RAM; only cfg_ writes are taken
// meanwhile. A result waits in the output register while the next item is taken;
// the block stalls only when a new sample finds the register still full.
module wavetable_sound_channel_mixer_unit
    import wsm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [6:0]         s_ram_addr,
    input  logic [7:0]         s_ram_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam logic [4:0] ST_CLEAR = 5'd0,  ST_IDLE = 5'd1,
                           ST_SRD = 5'd3,  ST_SLAT = 5'd4,  ST_SCALC = 5'd5,
                           ST_SWR = 5'd6,  ST_WRD = 5'd7,   ST_WLAT = 5'd8,
                           ST_SAMP = 5'd9, ST_SUM = 5'd10,  ST_GAIN = 5'd11,
                           ST_DIV = 5'd12, ST_DIVF = 5'd13, ST_DC0 = 5'd14,
                           ST_DCM = 5'd15, ST_DC1 = 5'd16,  ST_OUT = 5'd17,
                           ST_MOD = 5'd18, ST_WAIT = 5'd19, ST_TICK = 5'd20;

    logic [4:0]  state_reg, state_next;
    logic        enable_reg;
    logic [3:0]  active_reg;
    logic [15:0] divider_reg;
    logic [9:0]  gain_reg;
    logic [7:0]  svc_cnt_reg;
    logic [2:0]  svc_idx_reg;
    logic signed [7:0] level_reg [8];
    logic [15:0] samp_cnt_reg;
    logic signed [39:0] dc_reg;
    logic [6:0]  clr_reg;
    logic        m_valid_reg;
    logic signed [15:0] m_sample_reg;

    // working registers
    logic [2:0]  ch_reg;
    logic [2:0]  step_reg;
    logic [7:0]  b_reg [8];
    logic [24:0] ph_reg;
    logic [30:0] mod_reg;
    logic [6:0]  cnt_reg;
    logic signed [11:0] sum_reg;
    logic [21:0] prod_reg;
    logic [21:0] quo_reg;
    logic [21:0] rem_reg;
    logic        neg_reg;
    logic signed [40:0] d_reg;
    logic [40:0] dmag_reg;
    logic [56:0] acc_reg;
    logic signed [40:0] target_reg;

    logic [3:0] n;
    assign n = (active_reg == 4'd0) ? 4'd1 : (active_reg > 4'd8) ? 4'd8 : active_reg;

    // index modulo the channel count, which is 1 to 8
    function automatic logic [2:0] index_mod(logic [2:0] idx, logic [3:0] cnt);
        logic [2:0] res;
        case (cnt)
            4'd1:    res = 3'd0;
            4'd2:    res = {2'd0, idx[0]};
            4'd3:    res = (idx >= 3'd6) ? idx - 3'd6 : (idx >= 3'd3) ? idx - 3'd3 : idx;
            4'd4:    res = {1'b0, idx[1:0]};
            4'd8:    res = idx;
            default: res = (idx >= cnt[2:0]) ? idx - cnt[2:0] : idx;
        endcase
        return res;
    endfunction

    logic [2:0] svc_slot;
    logic [2:0] svc_slot_inc;
    assign svc_slot     = index_mod(svc_idx_reg, n);
    assign svc_slot_inc = ({1'b0, svc_slot} + 4'd1 == n) ? 3'd0 : svc_slot + 3'd1;

    logic       ram_we;
    logic [6:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    wsm_ram #(.WIDTH(8), .DEPTH(128)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [6:0] chan_addr;
    assign chan_addr = 7'(CHAN_BASE) + {1'b0, ch_reg, step_reg};

    logic [7:0] wave_idx;
    assign wave_idx = ph_reg[23:16] + b_reg[6];

    // wave nibble scaled by the channel volume
    logic [3:0]        wave_nib;
    logic signed [8:0] wave_level;
    assign wave_nib   = wave_idx[0] ? ram_rdata[7:4] : ram_rdata[3:0];
    assign wave_level = ($signed({5'd0, wave_nib}) - 9'sd8)
                        * $signed({5'd0, b_reg[7][3:0]});

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = chan_addr;
        ram_wdata = 8'd0;
        ram_raddr = chan_addr;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE: begin
                ram_we    = s_valid && s_command == CMD_WRITE;
                ram_waddr = s_ram_addr;
                ram_wdata = s_ram_data;
            end
            ST_SWR: begin
                ram_we    = 1'b1;
                ram_waddr = chan_addr;
                ram_wdata = (step_reg == 3'd1) ? ph_reg[7:0] :
                            (step_reg == 3'd3) ? ph_reg[15:8] : ph_reg[23:16];
                ram_raddr = wave_idx[7:1];
            end
            ST_WRD: begin
                ram_raddr = wave_idx[7:1];
            end
            default: ;
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

    // service tick decision
    logic       svc_fire;
    logic [7:0] svc_cnt_inc;
    assign svc_cnt_inc = svc_cnt_reg + 8'd1;
    assign svc_fire    = enable_reg && (svc_cnt_inc >= 8'(ServicePeriod));

    // multiplier slice for the dc coefficient
    logic [29:0] slice_prod;
    assign slice_prod = dmag_reg[15:0] * 14'(DcCoef);

    logic [21:0] rem_sh;
    assign rem_sh = {rem_reg[20:0], quo_reg[21]};

    // channel sum magnitude for the gain step
    logic [11:0] sum_mag;
    assign sum_mag = sum_reg[11] ? 12'(-sum_reg) : sum_reg;

    logic signed [40:0] out_full;
    logic signed [40:0] raw_s;
    logic signed [40:0] diff_out;
    logic signed [22:0] y;
    assign diff_out = target_reg - 41'(dc_reg);
    assign y = diff_out[40] ? -23'((-diff_out) >>> 18) : 23'(diff_out >>> 18);
    assign raw_s = neg_reg ? -41'({19'd0, quo_reg}) : 41'({19'd0, quo_reg});
    assign out_full = d_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == 7'h7f) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = (s_command == CMD_WRITE) ? ST_IDLE
                                                : ST_TICK;
            ST_TICK:  state_next = svc_fire ? ST_SRD : ST_SAMP;
            ST_SRD:   state_next = ST_SLAT;
            ST_SLAT:  state_next = (step_reg == 3'd7) ? ST_SCALC : ST_SRD;
            ST_SCALC: state_next = ST_MOD;
            ST_MOD:   state_next = (cnt_reg == 7'd6) ? ST_SWR : ST_MOD;
            ST_SWR:   state_next = (step_reg == 3'd5) ? ST_WRD : ST_SWR;
            ST_WRD:   state_next = ST_WLAT;
            ST_WLAT:  state_next = ST_SAMP;
            ST_SAMP:  state_next = (samp_cnt_reg + 16'd1 < divider_reg) ? ST_IDLE : ST_SUM;
            ST_SUM:   state_next = (cnt_reg == 7'd7) ? ST_GAIN : ST_SUM;
            ST_GAIN:  state_next = ST_DIV;
            ST_DIV:   state_next = (cnt_reg == 7'd21) ? ST_DIVF : ST_DIV;
            ST_DIVF:  state_next = ST_DC0;
            ST_DC0:   state_next = ST_DCM;
            ST_DCM:   state_next = (cnt_reg == 7'd2) ? ST_DC1 : ST_DCM;
            ST_DC1:   state_next = ST_WAIT;
            ST_WAIT:  state_next = (!m_valid_reg || m_ready) ? ST_OUT : ST_WAIT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            enable_reg   <= 1'b1;
            active_reg   <= 4'd1;
            divider_reg  <= 16'd40;
            gain_reg     <= 10'd256;
            svc_cnt_reg  <= 8'd0;
            svc_idx_reg  <= 3'd0;
            samp_cnt_reg <= 16'd0;
            dc_reg       <= 40'sd0;
            clr_reg      <= 7'd0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < 8; i++) level_reg[i] <= 8'sd0;
        end else begin
            state_reg <= state_next;
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLE:  enable_reg  <= cfg_data[0];
                    CFG_ACTIVE:  active_reg  <= cfg_data[3:0];
                    CFG_DIVIDER: divider_reg <= cfg_data;
                    CFG_GAIN:    gain_reg    <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 7'd1;
                ST_TICK: begin
                    if (enable_reg) begin
                        svc_cnt_reg <= svc_fire ? 8'd0 : svc_cnt_inc;
                    end
                    if (svc_fire) begin
                        ch_reg      <= 3'd7 - svc_slot;
                        svc_idx_reg <= svc_slot_inc;
                    end
                    step_reg <= 3'd0;
                end
                ST_SLAT: begin
                    b_reg[step_reg] <= ram_rdata;
                    step_reg <= step_reg + 3'd1;
                end
                ST_SCALC: begin
                    ph_reg  <= {1'b0, b_reg[5], b_reg[3], b_reg[1]}
                               + {7'd0, b_reg[4][1:0], b_reg[2], b_reg[0]};
                    mod_reg <= {9'd256 - {1'b0, b_reg[4] & 8'hfc}, 22'd0};
                    cnt_reg <= 7'd0;
                    step_reg <= 3'd1;
                end
                // phase reduction by the shifted wave length, one step per cycle
                ST_MOD: begin
                    if ({6'd0, ph_reg} >= mod_reg) ph_reg <= ph_reg - mod_reg[24:0];
                    mod_reg <= mod_reg >> 1;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_SWR: step_reg <= step_reg + 3'd2;
                ST_WLAT: begin
                    level_reg[ch_reg] <= wave_level[7:0];
                end
                ST_SAMP: begin
                    samp_cnt_reg <= (samp_cnt_reg + 16'd1 < divider_reg)
                                    ? samp_cnt_reg + 16'd1 : 16'd0;
                    sum_reg <= 12'sd0;
                    cnt_reg <= 7'd0;
                end
                ST_SUM: begin
                    if (enable_reg && (4'(cnt_reg) >= 4'd8 - n))
                        sum_reg <= sum_reg + 12'(level_reg[cnt_reg[2:0]]);
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_GAIN: begin
                    neg_reg  <= sum_reg[11];
                    prod_reg <= {10'd0, sum_mag} * {12'd0, gain_reg};
                    cnt_reg  <= 7'd0;
                    rem_reg  <= 22'd0;
                end
                ST_DIV: begin
                    if (cnt_reg == 7'd0) begin
                        quo_reg <= prod_reg;
                    end else begin
                        if (rem_sh >= 22'(n)) begin
                            rem_reg <= rem_sh - 22'(n);
                            quo_reg <= {quo_reg[20:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[20:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_DIVF: begin
                    if (rem_sh >= 22'(n)) quo_reg <= {quo_reg[20:0], 1'b1};
                    else quo_reg <= {quo_reg[20:0], 1'b0};
                end
                ST_DC0: begin
                    target_reg <= raw_s <<< 18;
                    d_reg    <= (raw_s <<< 18) - 41'(dc_reg);
                    dmag_reg <= 41'(((raw_s <<< 18) - 41'(dc_reg)) < 0
                                ? -((raw_s <<< 18) - 41'(dc_reg))
                                :   (raw_s <<< 18) - 41'(dc_reg));
                    acc_reg <= 57'd0;
                    cnt_reg <= 7'd0;
                end
                ST_DCM: begin
                    acc_reg  <= acc_reg + (57'(slice_prod) << (cnt_reg[1:0] * 16));
                    dmag_reg <= dmag_reg >> 16;
                    cnt_reg  <= cnt_reg + 7'd1;
                end
                ST_DC1: begin
                    dc_reg <= dc_reg + 40'(out_full[40]
                              ? (-$signed({1'b0, acc_reg}) + 58'sd8388608) >>> 24
                              : ($signed({1'b0, acc_reg}) + 58'sd8388608) >>> 24);
                end
                ST_OUT: begin
                    m_valid_reg  <= 1'b1;
                    m_sample_reg <= (y < -23'sd32768) ? 16'sh8000 :
                                    (y > 23'sd32767) ? 16'sd32767 : 16'(y);
                end
                default: ;
            endcase
        end
    end

    // a result never appears while still busy clearing
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result during ram clear");
    // service index stays below eight
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> {1'b0, svc_idx_reg} < 4'd8)
        else $error("service index out of range");
    // new result only when output free
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> (!m_valid_reg || m_ready))
        else $error("output overwritten");
endmodule

### sv/wsm_ram.sv
`timescale 1ns / 1ps
module wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### tb/wavetable_sound_channel_mixer_unit_tb.sv
`timescale 1ns / 1ps
module wavetable_sound_channel_mixer_unit_tb
    import wsm_pkg::*;
();

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [6:0]         s_ram_addr;
    logic [7:0]         s_ram_data;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_sample;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // predictor state
    logic [7:0]         snd_ram [128];
    logic [7:0]         svc_count;
    logic [2:0]         svc_index;
    int                 chan_level [8];
    logic [15:0]        smp_count;
    longint             dc_acc;
    logic               cur_enable;
    logic [3:0]         cur_active;
    logic [15:0]        cur_divider;
    logic [9:0]         cur_gain;

    logic signed [15:0] sample_queue [$];
    int                 error_count;
    bit                 hold_off;
    int                 stall_pct;

    wavetable_sound_channel_mixer_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_ram_addr (s_ram_addr),
        .s_ram_data (s_ram_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (m_sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // global timeout
    initial begin
        #400ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int clamp_count();
        if (cur_active < 1) return 1;
        if (cur_active > 8) return 8;
        return int'(cur_active);
    endfunction

    function automatic void advance_channel(int ch);
        int     b;
        int     len;
        logic [31:0] freq;
        logic [31:0] phase;
        logic [7:0]  idx;
        logic [7:0]  byte_val;
        int     nib;
        b = 'h40 + ch * 8;
        freq  = {14'd0, snd_ram[b+4][1:0], snd_ram[b+2], snd_ram[b]};
        phase = {8'd0, snd_ram[b+5], snd_ram[b+3], snd_ram[b+1]};
        len = 256 - int'(snd_ram[b+4] & 8'hFC);
        phase = (phase + freq) % (32'(len) << 16);
        snd_ram[b+1] = phase[7:0];
        snd_ram[b+3] = phase[15:8];
        snd_ram[b+5] = phase[23:16];
        idx = phase[23:16] + snd_ram[b+6];
        byte_val = snd_ram[idx[7:1]];
        nib = idx[0] ? int'(byte_val[7:4]) : int'(byte_val[3:0]);
        chan_level[ch] = (nib - 8) * int'(snd_ram[b+7][3:0]);
    endfunction

    function automatic longint floor_div24(longint x);
        if (x >= 0) return x >>> 24;
        return -((-x + (64'd1 << 24) - 1) >>> 24);
    endfunction

    // predicts one item; queues a sample on a sample tick
    function automatic void predict_item(logic cmd, logic [6:0] addr, logic [7:0] data);
        longint raw;
        longint target;
        longint y;
        int     n;
        int     sum;
        raw = 0;
        if (cmd == CMD_WRITE) begin
            snd_ram[addr] = data;
            return;
        end
        if (cur_enable) begin
            svc_count = svc_count + 8'd1;
            if (svc_count >= ServicePeriod) begin
                svc_count = 8'd0;
                n = clamp_count();
                advance_channel(7 - (int'(svc_index) % n));
                svc_index = 3'((int'(svc_index) + 1) % n);
            end
        end
        smp_count = smp_count + 16'd1;
        if (smp_count < cur_divider) return;
        smp_count = 16'd0;
        if (cur_enable) begin
            n = clamp_count();
            sum = 0;
            for (int ch = 8 - n; ch < 8; ch++) sum += chan_level[ch];
            raw = longint'(sum) * longint'(cur_gain) / n;
        end
        target = raw * (64'sd1 << 18);
        dc_acc += floor_div24((target - dc_acc) * DcCoef + (64'sd1 << 23));
        y = (target - dc_acc) / (64'sd1 << 18);
        if (y < -32768) y = -32768;
        if (y > 32767) y = 32767;
        sample_queue.insert(sample_queue.size(), 16'(y));
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sample_queue.size() == 0) begin
                $error("unexpected sample %0d", m_sample);
                error_count++;
            end else begin
                if (m_sample !== sample_queue[0]) begin
                    $error("sample: expected %0d, actual %0d", sample_queue[0], m_sample);
                    error_count++;
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(logic cmd, logic [6:0] addr, logic [7:0] data);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_ram_addr <= addr;
        s_ram_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(cmd, addr, data);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sample_queue.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:  cur_enable  = val[0];
            CFG_ACTIVE:  cur_active  = val[3:0];
            CFG_DIVIDER: cur_divider = val;
            default:     cur_gain    = val[9:0];
        endcase
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 7'($urandom()), 8'($urandom()));
    endtask

    task automatic send_bursty(int count, int tick_pct);
        int left;
        left = count;
        while (left > 0) begin
            for (int k = $urandom_range(1, 30); k > 0 && left > 0; k--) begin
                if ($urandom_range(99) < tick_pct) send_tick();
                else send_item(CMD_WRITE, 7'($urandom()), 8'($urandom()));
                left--;
            end
            if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 6));
        end
        s_valid <= 1'b0;
    endtask

    // random channel setup with wave data
    task automatic load_channels();
        for (int a = 0; a < 'h40; a++) send_item(CMD_WRITE, 7'(a), 8'($urandom()));
        for (int a = 'h40; a < 128; a++) send_item(CMD_WRITE, 7'(a), 8'($urandom()));
        s_valid <= 1'b0;
    endtask

    // extremes of fields and the reset settings
    task automatic test_directed();
        send_item(CMD_WRITE, 7'h7F, 8'hFF);
        send_item(CMD_WRITE, 7'h00, 8'h00);
        send_item(CMD_WRITE, 7'h47, 8'h0F);
        send_item(CMD_WRITE, 7'h7F, 8'h0F);
        send_item(CMD_WRITE, 7'h7C, 8'hFF);
        send_item(CMD_WRITE, 7'h78, 8'hFF);
        send_item(CMD_WRITE, 7'h7A, 8'hFF);
        send_item(CMD_WRITE, 7'h7D, 8'hFF);
        send_item(CMD_WRITE, 7'h55, 8'hAA);
        send_item(CMD_WRITE, 7'h2A, 8'h55);
        for (int i = 0; i < 15; i++) send_tick();
        wait_drained();
    endtask

    // zero divider, out-of-range counts, disable and full gain
    task automatic test_register_extremes();
        write_reg(CFG_DIVIDER, 16'd0);
        write_reg(CFG_ACTIVE, 16'd0);
        write_reg(CFG_GAIN, 16'd1023);
        send_bursty(40, 100);
        wait_drained();
        write_reg(CFG_ACTIVE, 16'd15);
        write_reg(CFG_DIVIDER, 16'd1);
        send_bursty(60, 100);
        wait_drained();
        write_reg(CFG_ENABLE, 16'd0);
        send_bursty(30, 100);
        wait_drained();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_GAIN, 16'd0);
        send_bursty(20, 100);
        wait_drained();
        write_reg(CFG_DIVIDER, 16'hFFFF);
        write_reg(CFG_GAIN, 16'd1023);
        send_bursty(20, 100);
        wait_drained();
        // lowering the divider mid-count fires on the next tick
        write_reg(CFG_DIVIDER, 16'd2);
        send_bursty(10, 100);
        wait_drained();
    endtask

    // random traffic over several settings
    task automatic test_random_traffic();
        for (int phase_i = 0; phase_i < 8; phase_i++) begin
            write_reg(CFG_ACTIVE, 16'($urandom_range(1, 8)));
            write_reg(CFG_DIVIDER, 16'($urandom_range(1, 12)));
            write_reg(CFG_GAIN, 16'($urandom_range(1023)));
            write_reg(CFG_ENABLE, 16'($urandom_range(7) != 0));
            stall_pct = (phase_i % 3 == 0) ? 0 : $urandom_range(10, 60);
            if (phase_i == 2) load_channels();
            send_bursty(160, 85);
            wait_drained();
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_back_pressure();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_DIVIDER, 16'd1);
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_bursty(40, 100);
        join
        wait_drained();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_command  = CMD_TICK;
        s_ram_addr = '0;
        s_ram_data = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ENABLE;
        cfg_data   = '0;
        hold_off   = 1'b0;
        stall_pct  = 20;
        error_count = 0;
        for (int i = 0; i < 128; i++) snd_ram[i] = 8'd0;
        for (int i = 0; i < 8; i++) chan_level[i] = 0;
        svc_count = 8'd0;
        svc_index = 3'd0;
        smp_count = 16'd0;
        dc_acc = 0;
        cur_enable = 1'b1;
        cur_active = 4'd1;
        cur_divider = 16'd40;
        cur_gain = 10'd256;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_back_pressure();
        wait_drained();

        if (error_count == 0 && sample_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
